### src/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared widths, codes and payload types of the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int ENTRIES = 16;
   localparam int KEY_W   = 32;
   localparam int DATA_W  = 32;
   localparam int CAP_W   = 5;
   localparam int AGE_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic FUNC_GET = 1'b0;
   localparam logic FUNC_SET = 1'b1;

   localparam logic [DATA_W-1:0] MISS_VALUE = {DATA_W{1'b1}};

   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [DATA_W-1:0]  data_type;
   typedef logic [AGE_W-1:0]   age_type;
   typedef logic [CNT_W-1:0]   cnt_type;
   typedef logic [ENTRIES-1:0] vec_type;

   typedef struct packed {
      logic                     func;
      logic signed [KEY_W-1:0]  lookup_key;
      logic signed [DATA_W-1:0] store_value;
   } req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] read_value;
   } rsp_type;

   typedef struct packed {
      logic             valid;
      req_type          req;
      logic [CAP_W-1:0] capacity;
   } op_type;

   typedef struct packed {
      logic     hit;
      vec_type  hit_oh;
      vec_type  free_oh;
      vec_type  victim_oh;
      data_type hit_data;
      age_type  hit_age;
   } match_type;

endpackage

### src/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Takes one request beat per cycle while no get is held by back-pressure on
// rsp, and answers every get with one response beat (hit and value, or miss
// and all ones); a set gives no response. A combinational parallel key
// compare over all entries and a parallel age update lie between the request
// register and the response register. Back-pressure on rsp holds a pending get
// in the request register; sets keep flowing. The store is empty right after
// reset, with no clearing pass. Write csr_wr_data (capacity) only while idle;
// zero reads as one and values above the entry count saturate.
module lru_key_value_cache
   import lkvc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data
);

   logic             in_valid_ff, in_valid_in;
   req_type          in_data_ff, in_data_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic    out_free;
   logic    advance;
   logic    is_get;
   op_type  op;
   rsp_type result;

   assign is_get    = (in_data_ff.func == FUNC_GET);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!is_get || out_free);
   assign req_ready = !in_valid_ff || advance;

   assign op.valid    = advance;
   assign op.req      = in_data_ff;
   assign op.capacity = cap_ff;

   lkvc_store u_store (
      .clock  (clock),
      .reset  (reset),
      .op     (op),
      .result (result)
   );

   always_comb begin
      in_valid_in = req_ready ? req_valid : in_valid_ff;
      in_data_in  = (req_valid && req_ready) ? req_data : in_data_ff;
      cap_in      = csr_wr_en ? csr_wr_data : cap_ff;

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance && is_get) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ready) begin
         // drop the beat once taken
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAP_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_ff       <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### src/lkvc_match.sv
// ----------------------------------------------------------------------------
// lkvc_match
// Parallel key compare over all entries; picks hit, free slot and victim.
// ----------------------------------------------------------------------------
module lkvc_match
   import lkvc_pkg::*;
(
   input  vec_type   entry_valid,
   input  key_type   entry_key [ENTRIES],
   input  data_type  entry_data [ENTRIES],
   input  age_type   entry_age [ENTRIES],
   input  cnt_type   fill_count,
   input  key_type   key,
   output match_type result
);

   vec_type  hit_oh;
   vec_type  victim_oh;
   vec_type  empty;
   data_type hit_data;
   age_type  hit_age;
   cnt_type  fill_m1;

   assign fill_m1 = fill_count - 1'b1;
   assign empty   = ~entry_valid;

   always_comb begin
      hit_data = '0;
      hit_age  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_oh[i]    = entry_valid[i] && (entry_key[i] == key);
         // the oldest valid entry carries age fill_count-1
         victim_oh[i] = entry_valid[i] && (entry_age[i] == AGE_W'(fill_m1));
         hit_data     = hit_data | (entry_data[i] & {DATA_W{hit_oh[i]}});
         hit_age      = hit_age  | (entry_age[i]  & {AGE_W{hit_oh[i]}});
      end
   end

   always_comb begin
      result.hit       = |hit_oh;
      result.hit_oh    = hit_oh;
      // isolate the lowest empty slot
      result.free_oh   = empty & (~empty + 1'b1);
      result.victim_oh = victim_oh;
      result.hit_data  = hit_data;
      result.hit_age   = hit_age;
   end

endmodule

### src/lkvc_store.sv
// ----------------------------------------------------------------------------
// lkvc_store
// Entry storage and registered recency update for one access per cycle.
// ----------------------------------------------------------------------------
module lkvc_store
   import lkvc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  op_type  op,
   output rsp_type result
);

   vec_type   valid_ff, valid_in;
   key_type   key_ff [ENTRIES];
   key_type   key_in [ENTRIES];
   data_type  data_ff [ENTRIES];
   data_type  data_in [ENTRIES];
   age_type   age_ff [ENTRIES];
   age_type   age_in [ENTRIES];
   cnt_type   fill_ff, fill_in;

   match_type       match;
   logic [CMP_W-1:0] cap_ext;
   logic [CMP_W-1:0] cap_eff;
   logic            is_set;
   logic            room;
   logic            insert;
   vec_type         tgt_oh;
   cnt_type         thr;

   lkvc_match u_match (
      .entry_valid (valid_ff),
      .entry_key   (key_ff),
      .entry_data  (data_ff),
      .entry_age   (age_ff),
      .fill_count  (fill_ff),
      .key         (op.req.lookup_key),
      .result      (match)
   );

   assign cap_ext = CMP_W'(op.capacity);
   assign is_set  = (op.req.func == FUNC_SET);

   always_comb begin
      if (cap_ext == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_ext > CMP_W'(ENTRIES)) begin
         cap_eff = CMP_W'(ENTRIES);
      end else begin
         cap_eff = cap_ext;
      end
   end

   assign room   = CMP_W'(fill_ff) < cap_eff;
   assign insert = op.valid && is_set && !match.hit && room;

   // An insert ages every valid entry, which is a touch with threshold fill_count.
   always_comb begin
      if (match.hit) begin
         tgt_oh = match.hit_oh;
         thr    = CNT_W'(match.hit_age);
      end else if (is_set && room) begin
         tgt_oh = match.free_oh;
         thr    = fill_ff;
      end else if (is_set) begin
         tgt_oh = match.victim_oh;
         thr    = fill_ff - 1'b1;
      end else begin
         tgt_oh = '0;
         thr    = '0;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      fill_in  = fill_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         key_in[i]  = key_ff[i];
         data_in[i] = data_ff[i];
         age_in[i]  = age_ff[i];
      end
      if (op.valid) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (tgt_oh[i]) begin
               age_in[i] = '0;
               if (is_set) begin
                  key_in[i]  = op.req.lookup_key;
                  data_in[i] = op.req.store_value;
               end
            end else if (valid_ff[i] && (CNT_W'(age_ff[i]) < thr)) begin
               age_in[i] = age_ff[i] + 1'b1;
            end
         end
         if (insert) begin
            valid_in = valid_ff | tgt_oh;
            fill_in  = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         key_ff[i]  <= key_in[i];
         data_ff[i] <= data_in[i];
         age_ff[i]  <= age_in[i];
      end
   end

   assign result.hit        = match.hit;
   assign result.read_value = match.hit ? match.hit_data : MISS_VALUE;

endmodule

### src/lkvc_checker.sv
// ----------------------------------------------------------------------------
// lkvc_checker
// Port-level checks of the LRU key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkvc_checker
   import lkvc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input req_type          req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rsp_type          rsp_data
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // a miss always reports all ones
   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.read_value == MISS_VALUE)
      else $error("miss response without all-ones value");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a fresh response comes from an accepted get
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_valid && req_ready && (req_data.func == FUNC_GET), 2))
      else $error("response beat without a matching get");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (.*);

### sim/lru_key_value_cache_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb
// Self-checking bench for the LRU key-value cache.
// ----------------------------------------------------------------------------
// Drives get and set requests through the valid/ready request channel and
// predicts every get response with a behavioral LRU store kept in the bench.
// Directed tests cover misses on an empty store, extreme keys and values,
// overwrite, recency refresh, eviction order and the capacity corner values
// (zero, saturation, shrinking below the fill level). Random traffic follows
// across several capacity settings and sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module lru_key_value_cache_tb;
   import lkvc_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 4;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;
   logic             csr_wr_en;
   logic [CAP_W-1:0] csr_wr_data;

   // behavioral copy of the store
   logic             lines_valid [ENTRIES];
   key_type          lines_key   [ENTRIES];
   data_type         lines_data  [ENTRIES];
   age_type          lines_age   [ENTRIES];
   int               lines_fill;
   logic [CAP_W-1:0] cap_setting;

   rsp_type pending_reads [$];
   int      error_count = 0;
   int      send_idle_pct = 0;
   int      rsp_stall_pct = 0;
   int      idle_cycles = 0;

   lru_key_value_cache u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void note_error(input string msg);
      if (error_count < 10) begin
         $display("%s", msg);
      end
      error_count++;
   endfunction

   // Make a line most recent: younger lines age by one.
   function automatic void refresh_line(input int slot);
      age_type prior;
      prior = lines_age[slot];
      for (int i = 0; i < ENTRIES; i++) begin
         if (lines_valid[i] && lines_age[i] < prior) begin
            lines_age[i]++;
         end
      end
      lines_age[slot] = '0;
   endfunction

   function automatic bit predict_access(input req_type r, output rsp_type rsp);
      int slot;
      int victim;
      int limit;
      slot = -1;
      victim = -1;
      rsp = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot < 0 && lines_valid[i] && lines_key[i] == key_type'(r.lookup_key)) begin
            slot = i;
         end
      end
      if (r.func == FUNC_GET) begin
         rsp.hit = (slot >= 0);
         rsp.read_value = MISS_VALUE;
         if (slot >= 0) begin
            rsp.read_value = lines_data[slot];
            refresh_line(slot);
         end
         return 1'b1;
      end
      if (slot >= 0) begin
         lines_data[slot] = r.store_value;
         refresh_line(slot);
         return 1'b0;
      end
      limit = (cap_setting == 0) ? 1 : (cap_setting > ENTRIES) ? ENTRIES : int'(cap_setting);
      if (lines_fill < limit) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (!lines_valid[i]) begin
               slot = i;
               break;
            end
         end
         for (int i = 0; i < ENTRIES; i++) begin
            if (lines_valid[i]) begin
               lines_age[i]++;
            end
         end
         lines_valid[slot] = 1'b1;
         lines_key[slot] = r.lookup_key;
         lines_data[slot] = r.store_value;
         lines_age[slot] = '0;
         lines_fill++;
         return 1'b0;
      end
      // replace the least recent line
      for (int i = 0; i < ENTRIES; i++) begin
         if (lines_valid[i] && (victim < 0 || lines_age[i] > lines_age[victim])) begin
            victim = i;
         end
      end
      if (victim >= 0) begin
         lines_key[victim] = r.lookup_key;
         lines_data[victim] = r.store_value;
         refresh_line(victim);
      end
      return 1'b0;
   endfunction

   function automatic req_type make_req(input logic func, input key_type key,
                                        input data_type value);
      req_type r;
      r.func = func;
      r.lookup_key = key;
      r.store_value = value;
      return r;
   endfunction

   // Send one request beat; valid stays high across back-to-back beats.
   task automatic send_request(input req_type item);
      rsp_type rsp;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      if (predict_access(item, rsp)) begin
         pending_reads.push_back(rsp);
      end
   endtask

   // Drain the cache, let trailing sets settle, then write the capacity.
   task automatic write_capacity(input logic [CAP_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      cap_setting = value;
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_basic_access();
      send_request(make_req(FUNC_GET, 32'h0000_0000, 32'h5a5a_5a5a));
      send_request(make_req(FUNC_SET, 32'h8000_0000, 32'h7fff_ffff));
      send_request(make_req(FUNC_SET, 32'h7fff_ffff, 32'h8000_0000));
      send_request(make_req(FUNC_GET, 32'h8000_0000, 32'hffff_ffff));
      send_request(make_req(FUNC_GET, 32'h7fff_ffff, 32'h0000_0000));
      send_request(make_req(FUNC_SET, 32'h0000_0000, 32'h0000_0000));
      send_request(make_req(FUNC_SET, 32'hffff_ffff, 32'hffff_ffff));
      // a hit on all ones must still raise hit
      send_request(make_req(FUNC_GET, 32'hffff_ffff, 32'h1234_5678));
      send_request(make_req(FUNC_SET, 32'h8000_0000, 32'h1234_5678));
      send_request(make_req(FUNC_GET, 32'h8000_0000, 32'h0000_0000));
      send_request(make_req(FUNC_GET, 32'h0000_0000, 32'hffff_ffff));
   endtask

   task automatic test_eviction_order();
      // four lines held, capacity two: every new key replaces the oldest
      write_capacity(CAP_W'(2));
      send_request(make_req(FUNC_SET, 32'h0000_0005, 32'h0000_0055));
      send_request(make_req(FUNC_GET, 32'h7fff_ffff, 32'h0000_0000));
      send_request(make_req(FUNC_SET, 32'h0000_0006, 32'h0000_0066));
      send_request(make_req(FUNC_GET, 32'h0000_0000, 32'h0000_0000));
      send_request(make_req(FUNC_GET, 32'h0000_0005, 32'h0000_0000));
      send_request(make_req(FUNC_GET, 32'h0000_0006, 32'h0000_0000));
   endtask

   task automatic test_capacity_corners();
      write_capacity(CAP_W'(0));
      send_request(make_req(FUNC_SET, 32'h0000_0007, 32'h0000_0077));
      send_request(make_req(FUNC_GET, 32'h0000_0007, 32'h0000_0000));
      send_request(make_req(FUNC_GET, 32'h0000_0006, 32'h0000_0000));
      write_capacity(CAP_W'(31));
      send_request(make_req(FUNC_SET, 32'h0000_0008, 32'h0000_0088));
      send_request(make_req(FUNC_GET, 32'h0000_0008, 32'h0000_0000));
   endtask

   task automatic test_random_traffic();
      logic [CAP_W-1:0] cap_plan [8] = '{CAP_W'(16), CAP_W'(4), CAP_W'(0), CAP_W'(31),
                                         CAP_W'(1), CAP_W'(9), CAP_W'(17), CAP_W'(12)};
      key_type pool [24];
      req_type item;
      int pool_span;
      for (int ph = 0; ph < 8; ph++) begin
         send_idle_pct = 0;
         rsp_stall_pct = 0;
         write_capacity(cap_plan[ph]);
         case (ph % 4)
            1: begin
               send_idle_pct = 73;
            end
            2: begin
               rsp_stall_pct = 73;
            end
            3: begin
               send_idle_pct = 37;
               rsp_stall_pct = 37;
            end
            default: ;
         endcase
         pool[0] = 32'h8000_0000;
         pool[1] = 32'h7fff_ffff;
         pool[2] = 32'h0000_0000;
         pool[3] = 32'hffff_ffff;
         for (int i = 4; i < 24; i++) begin
            pool[i] = $urandom;
         end
         // small capacities get a tight key set so hits still happen
         pool_span = (cap_plan[ph] <= 4) ? 6 : 24;
         repeat (240) begin
            item.func = 1'($urandom_range(1));
            item.lookup_key = ($urandom_range(9) == 0) ? key_type'($urandom)
                                                      : pool[$urandom_range(pool_span - 1)];
            item.store_value = $urandom;
            send_request(item);
         end
      end
      req_valid <= 1'b0;
   endtask

   // response check and receiver stalls
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reads.size() == 0) begin
            note_error($sformatf("unexpected response beat: hit %0b value %h",
                                 rsp_data.hit, rsp_data.read_value));
         end else begin
            want = pending_reads.pop_front();
            if (rsp_data.hit !== want.hit || rsp_data.read_value !== want.read_value) begin
               note_error($sformatf("response mismatch: expected hit %0b value %h, got hit %0b value %h",
                                    want.hit, want.read_value, rsp_data.hit, rsp_data.read_value));
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   initial begin : watchdog
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("lru_key_value_cache_tb: errors");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
         lines_valid[i] = 1'b0;
         lines_key[i] = '0;
         lines_data[i] = '0;
         lines_age[i] = '0;
      end
      lines_fill = 0;
      cap_setting = CAP_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_access();
      test_eviction_order();
      test_capacity_corners();
      test_random_traffic();

      while (pending_reads.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("lru_key_value_cache_tb: clean");
      end else begin
         $display("lru_key_value_cache_tb: errors");
      end
      $finish;
   end

endmodule

### lru_key_value_cache.f
src/lkvc_pkg.sv
src/lkvc_match.sv
src/lkvc_store.sv
src/lru_key_value_cache.sv
src/lkvc_checker.sv
sim/lru_key_value_cache_tb.sv
